### rtl/nkm_pkg.sv
// ----------------------------------------------------------------------------
// nkm_pkg
// Shared types and constants for the nearest key match and remove unit.
// ----------------------------------------------------------------------------
package nkm_pkg;

    localparam int KEY_W     = 31;
    localparam int ACT_W     = 2;
    localparam int TOT_W     = 20;
    localparam int MOD_VAL   = 1000000;
    localparam int RED_STEPS = 12;

    typedef enum logic [ACT_W-1:0] {
        ACT_STORED  = 2'd0,
        ACT_MATCHED = 2'd1,
        ACT_DROPPED = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    // what a cell shows its neighbors
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             valid;
        logic             cond;   // empty or key above the search key
        logic             lo;     // nearest lower key, and chosen
    } t_cell_nb;

endpackage

### rtl/nkm_if.sv
// ----------------------------------------------------------------------------
// nkm_in_if / nkm_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface nkm_in_if import nkm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             side;
    logic [KEY_W-1:0] key_value;

    modport source (output valid, side, key_value, input ready);
    modport sink   (input valid, side, key_value, output ready);
endinterface

interface nkm_out_if import nkm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] matched_key;
    logic [KEY_W-1:0] distance;
    logic [TOT_W-1:0] running_total;

    modport source (output valid, action, matched_key, distance, running_total,
                    input ready);
    modport sink   (input valid, action, matched_key, distance, running_total,
                    output ready);
endinterface

### rtl/nearest_key_match_and_remove_unit.sv
// ----------------------------------------------------------------------------
// nearest_key_match_and_remove_unit
// Sorted chain of key cells; stores keys or removes the nearest stored key.
//
//   channel  dir  fields
//   i_in     in   side, key_value
//   o_out    out  action, matched_key, distance, running_total
//
// A store passes through the insert state before its result; a drop is
// answered from idle. A match runs the OR tree gathering the hit key, the
// chain shift, 12 restoring steps for the modulo, and the final add.
// One item is in flight; a new one is taken once the result beat leaves.
// Synchronous active-low reset empties the chain at once.
// ----------------------------------------------------------------------------
module nearest_key_match_and_remove_unit import nkm_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nkm_in_if.sink    i_in,
    nkm_out_if.source o_out
);

    localparam int LEVELS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(LEVELS + 1);
    localparam int SC_W   = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_INS, S_TREE, S_TAKE, S_RED, S_SUM} t_state;

    t_state           r_state;
    logic             r_side;
    logic [KEY_W-1:0] r_key;
    logic [SC_W-1:0]  r_count;
    logic             r_wside;
    logic [TOT_W-1:0] r_total;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_step;
    logic [KEY_W-1:0] r_rem;
    logic             r_out_valid;
    logic [ACT_W-1:0] r_action;
    logic [KEY_W-1:0] r_mkey;
    logic [KEY_W-1:0] r_dist;

    t_cell_op         w_op;
    t_cell_nb         w_nb   [CAPACITY];
    logic             w_hit  [CAPACITY];
    logic [KEY_W-1:0] w_leaf [CAPACITY];
    logic [KEY_W-1:0] w_root;
    logic [KEY_W-1:0] w_dist;
    logic [31:0]      w_sub;
    logic [TOT_W:0]   w_sum;
    logic             w_acc;

    assign w_op = (r_state == S_INS)  ? CELL_INSERT :
                  (r_state == S_TAKE) ? CELL_REMOVE : CELL_HOLD;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_nb w_prev;
        t_cell_nb w_next;
        if (i == 0) begin : g_first
            assign w_prev = '{key: '0, valid: 1'b1, cond: 1'b0, lo: 1'b0};
        end else begin : g_mid_p
            assign w_prev = w_nb[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_next = '{key: '0, valid: 1'b0, cond: 1'b1, lo: 1'b0};
        end else begin : g_mid_n
            assign w_next = w_nb[i+1];
        end
        nkm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_key   (r_key),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_self  (w_nb[i]),
            .o_hit   (w_hit[i])
        );
        assign w_leaf[i] = w_hit[i] ? w_nb[i].key : '0;
    end

    nkm_or_tree #(.N(CAPACITY)) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    assign w_dist = (w_root >= r_key) ? (w_root - r_key) : (r_key - w_root);
    assign w_sub  = 32'(MOD_VAL) << r_step;
    assign w_sum  = {1'b0, r_total} + {1'b0, r_rem[TOT_W-1:0]};
    assign w_acc  = i_in.valid && i_in.ready;

    assign i_in.ready          = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_action;
    assign o_out.matched_key   = r_mkey;
    assign o_out.distance      = r_dist;
    assign o_out.running_total = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wside     <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_step      <= '0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_side <= i_in.side;
                        r_key  <= i_in.key_value;
                        if (r_count == '0 || i_in.side == r_wside) begin
                            if (r_count == SC_W'(CAPACITY)) begin
                                r_out_valid <= 1'b1;
                                r_action    <= ACT_DROPPED;
                                r_mkey      <= '0;
                                r_dist      <= '0;
                            end else begin
                                r_state <= S_INS;
                            end
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_TREE;
                        end
                    end
                end
                S_INS: begin
                    r_count     <= r_count + 1'b1;
                    r_wside     <= r_side;
                    r_out_valid <= 1'b1;
                    r_action    <= ACT_STORED;
                    r_mkey      <= '0;
                    r_dist      <= '0;
                    r_state     <= S_IDLE;
                end
                S_TREE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(LEVELS - 1)) begin
                        r_state <= S_TAKE;
                    end
                end
                S_TAKE: begin
                    r_mkey  <= w_root;
                    r_dist  <= w_dist;
                    r_rem   <= w_dist;
                    r_count <= r_count - 1'b1;
                    r_step  <= 4'(RED_STEPS - 1);
                    r_state <= S_RED;
                end
                S_RED: begin
                    if ({1'b0, r_rem} >= w_sub) begin
                        r_rem <= KEY_W'({1'b0, r_rem} - w_sub);
                    end
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (w_sum >= (TOT_W+1)'(MOD_VAL)) begin
                        r_total <= TOT_W'(w_sum - (TOT_W+1)'(MOD_VAL));
                    end else begin
                        r_total <= w_sum[TOT_W-1:0];
                    end
                    r_out_valid <= 1'b1;
                    r_action    <= ACT_MATCHED;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/nkm_cell.sv
// ----------------------------------------------------------------------------
// nkm_cell
// One slot of the sorted key chain; shifts up on insert, down on remove.
// ----------------------------------------------------------------------------
module nkm_cell import nkm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_op         i_op,
    input  logic [KEY_W-1:0] i_key,
    input  t_cell_nb         i_prev,
    input  t_cell_nb         i_next,
    output t_cell_nb         o_self,
    output logic             o_hit
);

    logic [KEY_W-1:0] r_key;
    logic             r_valid;
    logic             w_cond;
    logic             w_lo;
    logic [KEY_W-1:0] w_dlo;
    logic [KEY_W-1:0] w_dhi;

    assign w_cond = !r_valid || (r_key > i_key);
    assign w_dlo  = i_key - r_key;
    assign w_dhi  = i_next.key - i_key;
    assign w_lo   = !w_cond && i_next.cond && (!i_next.valid || (w_dlo <= w_dhi));

    assign o_self = '{key: r_key, valid: r_valid, cond: w_cond, lo: w_lo};
    assign o_hit  = w_lo || (w_cond && r_valid && !i_prev.cond && !i_prev.lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                CELL_INSERT: begin
                    if (i_prev.cond) begin
                        r_valid <= i_prev.valid;
                        r_key   <= i_prev.key;
                    end else if (w_cond) begin
                        r_valid <= 1'b1;
                        r_key   <= i_key;
                    end
                end
                CELL_REMOVE: begin
                    if (w_cond || w_lo) begin
                        r_valid <= i_next.valid;
                        r_key   <= i_next.key;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/nkm_or_tree.sv
// ----------------------------------------------------------------------------
// nkm_or_tree
// Registered binary OR tree, one register per level, gathers the hit key.
// ----------------------------------------------------------------------------
module nkm_or_tree import nkm_pkg::*; #(
    parameter int N = 1024
) (
    input  logic             i_clk,
    input  logic [KEY_W-1:0] i_leaf [N],
    output logic [KEY_W-1:0] o_root
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
    localparam int P      = 1 << LEVELS;

    logic [KEY_W-1:0] w_leaf [P];
    logic [KEY_W-1:0] r_node [1:P-1];

    always_comb begin
        for (int i = 0; i < P; i++) begin
            w_leaf[i] = (i < N) ? i_leaf[i] : '0;
        end
    end

    for (genvar n = 1; n < P; n++) begin : g_node
        if (2 * n >= P) begin : g_bottom
            always_ff @(posedge i_clk) begin
                r_node[n] <= w_leaf[2*n-P] | w_leaf[2*n+1-P];
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_node[n] <= r_node[2*n] | r_node[2*n+1];
            end
        end
    end

    assign o_root = r_node[1];

endmodule

### rtl/nkm_checker.sv
// ----------------------------------------------------------------------------
// nkm_checker
// Port-level checks on the nearest key match and remove unit.
// ----------------------------------------------------------------------------
module nkm_checker import nkm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ACT_W-1:0] i_action,
    input logic [KEY_W-1:0] i_matched_key,
    input logic [KEY_W-1:0] i_distance,
    input logic [TOT_W-1:0] i_running_total
);

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_running_total < TOT_W'(MOD_VAL))
        else $error("running total out of range");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_action != ACT_MATCHED) |-> (i_matched_key == '0 && i_distance == '0))
        else $error("nonzero key or distance without match");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second beat taken while one in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_action)
            && $stable(i_running_total)))
        else $error("result beat changed while stalled");

endmodule

bind nearest_key_match_and_remove_unit nkm_checker u_nkm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_action        (o_out.action),
    .i_matched_key   (o_out.matched_key),
    .i_distance      (o_out.distance),
    .i_running_total (o_out.running_total)
);
